>>> hw/rtl/binomial_coefficient_mod_prime_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binomial coefficient block
// Shared property forms, clocked on clk and idle while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_COEFFICIENT_MOD_PRIME_TOP_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_MOD_PRIME_TOP_DEFINES_SVH

// Same-cycle implication
`define BCM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define BCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg
// Types, codes and widths shared by the binomial coefficient block.
// ----------------------------------------------------------------------------
package bcm_pkg;

	localparam int unsigned MW = 31;  // modulus and residue width
	localparam int unsigned NW = 12;  // width of n and k

	localparam logic CMD_REBUILD = 1'b0;
	localparam logic CMD_QUERY   = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_READY = 2'd1;
	localparam logic [1:0] ST_NO_INV    = 2'd2;

	typedef struct packed {
		logic          command;
		logic [NW-1:0] n_value;
		logic [NW-1:0] k_value;
	} bcm_req_t;

	typedef struct packed {
		logic [MW-1:0] coefficient;
		logic [1:0]    status;
	} bcm_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RB_ZERO,
		S_RB_ONE,
		S_FACT_STEP,
		S_FACT_WAIT,
		S_EUC_TEST,
		S_EUC_DIV_WAIT,
		S_EUC_MUL,
		S_EUC_MUL_WAIT,
		S_INV_INIT,
		S_INV_STEP,
		S_INV_WAIT,
		S_Q_RD1,
		S_Q_RD2,
		S_Q_MUL1_WAIT,
		S_Q_MUL2_WAIT,
		S_RESULT
	} bcm_state_t;

endpackage

>>> hw/rtl/binomial_coefficient_mod_prime_top.sv
// ----------------------------------------------------------------------------
// binomial_coefficient_mod_prime_top
// Binomial coefficients modulo a programmable modulus from factorial and
// inverse-factorial tables held in two synchronous memories.
// ----------------------------------------------------------------------------
//  channel | signals                      | payload
//  --------+------------------------------+--------------------------
//  in      | in_valid, in_stall, in_data  | command, n_value, k_value
//  out     | out_valid, out_stall, out_data | coefficient, status
//  cfg     | cfg_we, cfg_wdata            | modulus
//
//  A query runs from acceptance to the response through two table reads,
//  two passes of the bit-serial multiplier and the result state.
//  Error answers go straight from idle to the result state.
//  A rebuild fills the factorial table with one multiply per entry, inverts
//  the last factorial by Euclid (up to ~46 rounds of a divide and a multiply),
//  then fills the inverse table likewise. No clearing pass after reset.
//  One request is worked at a time; in_stall is high while it runs.
// ----------------------------------------------------------------------------
`include "binomial_coefficient_mod_prime_top_defines.svh"

module binomial_coefficient_mod_prime_top
	import bcm_pkg::*;
#(
	parameter int unsigned TABLE_SIZE = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  bcm_req_t      in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output bcm_rsp_t      out_data,
	input  logic          cfg_we,
	input  logic [MW-1:0] cfg_wdata
);

	localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

	// Table memories
	logic [MW-1:0] fact_mem [TABLE_SIZE];
	logic [MW-1:0] inv_mem  [TABLE_SIZE];

	bcm_state_t    state_q, state_d;
	logic          ready_q;
	logic [MW-1:0] mod_q;
	logic          out_valid_q;
	bcm_rsp_t      out_q;

	logic [AW-1:0] i_q;
	logic [MW-1:0] imod_q, f_q, r0_q, r1_q, s0_q, s1_q, q_q;
	logic [NW-1:0] n_q, k_q;
	logic [MW-1:0] res_coef_q;
	logic [1:0]    res_status_q;

	logic          fact_we, inv_we, fact_re, inv_re;
	logic [AW-1:0] fact_waddr, inv_waddr, fact_raddr, inv_raddr;
	logic [MW-1:0] fact_wdata, inv_wdata, fact_rd_q, inv_rd_q;

	logic          mm_start, mm_done, div_start, div_done;
	logic [MW-1:0] mm_a, mm_b, mm_res, div_quo, div_rem;

	logic          in_acc, out_load;
	logic [MW-1:0] imod_inc, imod_dec, q_red, s_sub;
	logic [NW-1:0] nk_diff;

	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == S_RESULT) && (!out_valid_q || !out_stall);
	assign nk_diff  = n_q - k_q;

	// Running residues of the table index, quotient reduction, modular subtract
	always_comb begin
		imod_inc = ((imod_q + MW'(1)) == mod_q) ? '0 : imod_q + MW'(1);
		imod_dec = (imod_q == '0) ? mod_q - MW'(1) : imod_q - MW'(1);
		q_red    = (div_quo >= mod_q) ? div_quo - mod_q : div_quo;
		s_sub    = (s0_q >= mm_res) ? s0_q - mm_res : s0_q - mm_res + mod_q;
	end

	bcm_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.m      (mod_q),
		.done   (mm_done),
		.res    (mm_res)
	);

	bcm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (r0_q),
		.divisor  (r1_q),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Next state, unit starts and memory strobes
	always_comb begin
		state_d    = state_q;
		mm_start   = 1'b0;
		mm_a       = imod_q;
		mm_b       = f_q;
		div_start  = 1'b0;
		fact_we    = 1'b0;
		fact_waddr = i_q;
		fact_wdata = mm_res;
		inv_we     = 1'b0;
		inv_waddr  = i_q - AW'(1);
		inv_wdata  = mm_res;
		fact_re    = 1'b0;
		fact_raddr = AW'(n_q);
		inv_re     = 1'b0;
		inv_raddr  = AW'(k_q);
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (in_data.command == CMD_REBUILD) begin
						state_d = (mod_q < MW'(2)) ? S_RESULT : S_RB_ZERO;
					end else if (!ready_q || (in_data.k_value > in_data.n_value) ||
					             (32'(in_data.n_value) >= 32'(TABLE_SIZE))) begin
						state_d = S_RESULT;
					end else begin
						state_d = S_Q_RD1;
					end
				end
			end
			S_RB_ZERO: begin
				fact_we    = 1'b1;
				fact_waddr = '0;
				fact_wdata = MW'(1);
				state_d    = S_RB_ONE;
			end
			S_RB_ONE: begin
				fact_we    = 1'b1;
				fact_waddr = AW'(1);
				fact_wdata = MW'(1);
				state_d    = S_FACT_STEP;
			end
			S_FACT_STEP: begin
				if (i_q == LAST) begin
					state_d = S_EUC_TEST;
				end else begin
					mm_start = 1'b1;
					mm_a     = imod_inc;
					state_d  = S_FACT_WAIT;
				end
			end
			S_FACT_WAIT: begin
				if (mm_done) begin
					fact_we = 1'b1;
					state_d = S_FACT_STEP;
				end
			end
			S_EUC_TEST: begin
				if (r1_q == '0) begin
					state_d = (r0_q == MW'(1)) ? S_INV_INIT : S_RESULT;
				end else begin
					div_start = 1'b1;
					state_d   = S_EUC_DIV_WAIT;
				end
			end
			S_EUC_DIV_WAIT: begin
				if (div_done) begin
					state_d = S_EUC_MUL;
				end
			end
			S_EUC_MUL: begin
				mm_start = 1'b1;
				mm_a     = q_q;
				mm_b     = s1_q;
				state_d  = S_EUC_MUL_WAIT;
			end
			S_EUC_MUL_WAIT: begin
				if (mm_done) begin
					state_d = S_EUC_TEST;
				end
			end
			S_INV_INIT: begin
				inv_we    = 1'b1;
				inv_waddr = LAST;
				inv_wdata = s0_q;
				state_d   = S_INV_STEP;
			end
			S_INV_STEP: begin
				if (i_q == '0) begin
					state_d = S_RESULT;
				end else begin
					mm_start = 1'b1;
					state_d  = S_INV_WAIT;
				end
			end
			S_INV_WAIT: begin
				if (mm_done) begin
					inv_we  = 1'b1;
					state_d = S_INV_STEP;
				end
			end
			S_Q_RD1: begin
				fact_re = 1'b1;
				inv_re  = 1'b1;
				state_d = S_Q_RD2;
			end
			S_Q_RD2: begin
				mm_start  = 1'b1;
				mm_a      = fact_rd_q;
				mm_b      = inv_rd_q;
				inv_re    = 1'b1;
				inv_raddr = AW'(nk_diff);
				state_d   = S_Q_MUL1_WAIT;
			end
			S_Q_MUL1_WAIT: begin
				if (mm_done) begin
					mm_start = 1'b1;
					mm_a     = mm_res;
					mm_b     = inv_rd_q;
					state_d  = S_Q_MUL2_WAIT;
				end
			end
			S_Q_MUL2_WAIT: begin
				if (mm_done) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Modulus, readiness and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q       <= MW'(1000000007);
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mod_q   <= cfg_wdata;
				ready_q <= 1'b0;
			end else if (in_acc && (in_data.command == CMD_REBUILD)) begin
				ready_q <= 1'b0;
			end else if ((state_q == S_INV_STEP) && (i_q == '0)) begin
				ready_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					n_q        <= in_data.n_value;
					k_q        <= in_data.k_value;
					res_coef_q <= '0;
					if (in_data.command == CMD_REBUILD) begin
						res_status_q <= (mod_q < MW'(2)) ? ST_NO_INV : ST_OK;
					end else if (!ready_q) begin
						res_status_q <= ST_NOT_READY;
					end else if (in_data.k_value > in_data.n_value) begin
						res_status_q <= ST_OK;
					end else if (32'(in_data.n_value) >= 32'(TABLE_SIZE)) begin
						res_status_q <= ST_NOT_READY;
					end else begin
						res_status_q <= ST_OK;
					end
				end
			end
			S_RB_ONE: begin
				i_q    <= AW'(1);
				imod_q <= MW'(1);
				f_q    <= MW'(1);
			end
			S_FACT_STEP: begin
				if (i_q == LAST) begin
					r0_q <= f_q;
					r1_q <= mod_q;
					s0_q <= MW'(1);
					s1_q <= '0;
				end else begin
					i_q    <= i_q + AW'(1);
					imod_q <= imod_inc;
				end
			end
			S_FACT_WAIT: begin
				if (mm_done) begin
					f_q <= mm_res;
				end
			end
			S_EUC_TEST: begin
				if ((r1_q == '0) && (r0_q != MW'(1))) begin
					res_status_q <= ST_NO_INV;
				end
			end
			S_EUC_DIV_WAIT: begin
				if (div_done) begin
					q_q  <= q_red;
					r0_q <= r1_q;
					r1_q <= div_rem;
				end
			end
			S_EUC_MUL_WAIT: begin
				if (mm_done) begin
					s0_q <= s1_q;
					s1_q <= s_sub;
				end
			end
			S_INV_INIT: begin
				f_q <= s0_q;
			end
			S_INV_WAIT: begin
				if (mm_done) begin
					f_q    <= mm_res;
					i_q    <= i_q - AW'(1);
					imod_q <= imod_dec;
				end
			end
			S_Q_MUL2_WAIT: begin
				if (mm_done) begin
					res_coef_q <= mm_res;
				end
			end
			S_RESULT: begin
				if (out_load) begin
					out_q.coefficient <= res_coef_q;
					out_q.status      <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Factorial memory
	always_ff @(posedge clk) begin
		if (fact_we) begin
			fact_mem[fact_waddr] <= fact_wdata;
		end
		if (fact_re) begin
			fact_rd_q <= fact_mem[fact_raddr];
		end
	end

	// Inverse-factorial memory
	always_ff @(posedge clk) begin
		if (inv_we) begin
			inv_mem[inv_waddr] <= inv_wdata;
		end
		if (inv_re) begin
			inv_rd_q <= inv_mem[inv_raddr];
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`BCM_ASSERT_NEXT(a_accept_busy, in_acc, in_stall, "request accepted but block still idle")
	`BCM_ASSERT_NOW(a_noinv_not_ready, (state_q == S_RESULT) && (res_status_q == ST_NO_INV), !ready_q, "failed rebuild left tables ready")
	`BCM_ASSERT_NOW(a_mm_done_wait, mm_done, (state_q == S_FACT_WAIT) || (state_q == S_EUC_MUL_WAIT) || (state_q == S_INV_WAIT) || (state_q == S_Q_MUL1_WAIT) || (state_q == S_Q_MUL2_WAIT), "multiplier finished outside a wait state")
	`BCM_ASSERT_NOW(a_div_done_wait, div_done, state_q == S_EUC_DIV_WAIT, "divider finished outside its wait state")

endmodule

>>> hw/rtl/bcm_mulmod.sv
// ----------------------------------------------------------------------------
// bcm_mulmod
// Bit-serial modular multiplier: res = a * b mod m, one bit of b per cycle,
// both operands below m. Done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module bcm_mulmod
	import bcm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] a,
	input  logic [MW-1:0] b,
	input  logic [MW-1:0] m,
	output logic          done,
	output logic [MW-1:0] res
);

	logic          busy_q;
	logic          done_q;
	logic [4:0]    cnt_q;
	logic [MW-1:0] r_q, a_q, b_q, m_q;
	logic [MW:0]   dbl, dbl_red, sum, sum_red;

	// Double, reduce, add the selected multiple, reduce
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		sum     = b_q[cnt_q] ? dbl_red + {1'b0, a_q} : dbl_red;
		sum_red = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(MW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	// Operands and running remainder
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			a_q <= a;
			b_q <= b;
			m_q <= m;
		end else if (busy_q) begin
			r_q <= sum_red[MW-1:0];
		end
	end

	assign done = done_q;
	assign res  = r_q;

endmodule

>>> hw/rtl/bcm_div.sv
// ----------------------------------------------------------------------------
// bcm_div
// Restoring divider, one quotient bit per cycle; divisor must be non-zero.
// ----------------------------------------------------------------------------
module bcm_div
	import bcm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] dividend,
	input  logic [MW-1:0] divisor,
	output logic          done,
	output logic [MW-1:0] quo,
	output logic [MW-1:0] rem
);

	logic          busy_q;
	logic          done_q;
	logic [4:0]    cnt_q;
	logic [MW-1:0] quo_q, rem_q, d_q;
	logic [MW:0]   trial;
	logic          fits;

	// Shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[MW-1]};
		fits  = (trial >= {1'b0, d_q});
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(MW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	// Quotient and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[MW-2:0], fits};
			rem_q <= fits ? MW'(trial - {1'b0, d_q}) : trial[MW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule
